// File: rtl/core/wsdf_pkg.sv
// Shared types and constants for the websocket frame deframer
`timescale 1ns / 1ps
`default_nettype none

package wsdf_pkg;

   // parser phases, one-hot
   typedef enum logic [5:0] {
      PH_FIRST   = 6'b000001,
      PH_SECOND  = 6'b000010,
      PH_EXTLEN  = 6'b000100,
      PH_MASK    = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_HALT    = 6'b100000
   } phase_type;

   // header byte fields
   localparam int unsigned FIN_BIT      = 7;
   localparam int unsigned MASK_BIT     = 7;
   localparam int unsigned OPCODE_WIDTH = 4;
   localparam int unsigned LEN7_WIDTH   = 7;

   // seven-bit length codes
   localparam logic [LEN7_WIDTH-1:0] LEN_MAX_SHORT = 7'd125;
   localparam logic [LEN7_WIDTH-1:0] LEN_EXT16     = 7'd126;

   // header byte counts
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   localparam int unsigned LENGTH_WIDTH = 64;
   localparam int unsigned KEY_WIDTH    = 32;

endpackage

`default_nettype wire

// File: rtl/core/websocket_frame_deframer.sv
// Websocket client-to-server frame parser with payload unmasking
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per transfer and parses the frame header (FIN, opcode, mask bit,
// 7-bit length with 16- or 64-bit extended length, 4-byte mask key). Each payload byte
// comes out XORed with its mask key byte, tagged with opcode and FIN, and the last byte of
// the frame carries frame_last. A zero-length frame gives one marker result without data.
// A frame without the mask bit gives one result with protocol_error set, after which every
// input byte is taken and dropped until reset. Other header bytes give no result. One byte
// is taken in every cycle without a stall: the parser state and the result register
// update in the cycle of the transfer; the input stalls only while a held result stalls.
module websocket_frame_deframer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_payload_valid,
   output logic [3:0]      rsp_opcode,
   output logic            rsp_final_fragment,
   output logic            rsp_frame_last,
   output logic            rsp_protocol_error
);
   import wsdf_pkg::*;

   // parser state
   phase_type                 phase_ff, phase_in;
   logic                      fin_ff, fin_in;
   logic [OPCODE_WIDTH-1:0]   opcode_ff, opcode_in;
   logic [LENGTH_WIDTH-1:0]   remaining_ff, remaining_in;
   logic [3:0]                hdr_count_ff, hdr_count_in;
   logic [KEY_WIDTH-1:0]      key_ff, key_in;
   logic [1:0]                key_index_ff, key_index_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_data_ff, rsp_data_in;
   logic                      rsp_data_valid_ff, rsp_data_valid_in;
   logic [OPCODE_WIDTH-1:0]   rsp_opcode_ff, rsp_opcode_in;
   logic                      rsp_fin_ff, rsp_fin_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_error_ff, rsp_error_in;

   logic                      accept;
   logic                      emit;
   logic [LEN7_WIDTH-1:0]     len7;
   logic [3:0]                hdr_count_dec;
   logic [7:0]                key_byte;

   // input side stalls only behind a stalled result
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign len7          = req_rx_byte[LEN7_WIDTH-1:0];
   assign hdr_count_dec = hdr_count_ff - 4'd1;

   // key byte for this offset, first key byte in the top bits
   always_comb begin
      case (key_index_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // parser next state and result
   always_comb begin
      phase_in          = phase_ff;
      fin_in            = fin_ff;
      opcode_in         = opcode_ff;
      remaining_in      = remaining_ff;
      hdr_count_in      = hdr_count_ff;
      key_in            = key_ff;
      key_index_in      = key_index_ff;
      emit              = 1'b0;
      rsp_data_in       = 8'd0;
      rsp_data_valid_in = 1'b0;
      rsp_opcode_in     = opcode_ff;
      rsp_fin_in        = fin_ff;
      rsp_last_in       = 1'b0;
      rsp_error_in      = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_FIRST: begin
               fin_in    = req_rx_byte[FIN_BIT];
               opcode_in = req_rx_byte[OPCODE_WIDTH-1:0];
               phase_in  = PH_SECOND;
            end
            PH_SECOND: begin
               if (!req_rx_byte[MASK_BIT]) begin
                  phase_in     = PH_HALT;
                  emit         = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_error_in = 1'b1;
               end else begin
                  key_in       = '0;
                  key_index_in = 2'd0;
                  if (len7 <= LEN_MAX_SHORT) begin
                     remaining_in = LENGTH_WIDTH'(len7);
                     hdr_count_in = KEY_BYTES;
                     phase_in     = PH_MASK;
                  end else begin
                     remaining_in = '0;
                     hdr_count_in = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                     phase_in     = PH_EXTLEN;
                  end
               end
            end
            PH_EXTLEN: begin
               remaining_in = {remaining_ff[LENGTH_WIDTH-9:0], req_rx_byte};
               hdr_count_in = hdr_count_dec;
               if (hdr_count_dec == 4'd0) begin
                  hdr_count_in = KEY_BYTES;
                  phase_in     = PH_MASK;
               end
            end
            PH_MASK: begin
               key_in       = {key_ff[KEY_WIDTH-9:0], req_rx_byte};
               hdr_count_in = hdr_count_dec;
               if (hdr_count_dec == 4'd0) begin
                  key_index_in = 2'd0;
                  if (remaining_ff == '0) begin
                     phase_in    = PH_FIRST;
                     emit        = 1'b1;
                     rsp_last_in = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               key_index_in      = key_index_ff + 2'd1;
               remaining_in      = remaining_ff - LENGTH_WIDTH'(1);
               emit              = 1'b1;
               rsp_data_in       = req_rx_byte ^ key_byte;
               rsp_data_valid_in = 1'b1;
               rsp_last_in       = (remaining_ff == LENGTH_WIDTH'(1));
               if (remaining_ff == LENGTH_WIDTH'(1)) begin
                  phase_in = PH_FIRST;
               end
            end
            default: begin
               // halted: drop the byte
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // result register holds until the transfer
   assign rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         fin_ff       <= 1'b0;
         opcode_ff    <= '0;
         remaining_ff <= '0;
         hdr_count_ff <= '0;
         key_ff       <= '0;
         key_index_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         remaining_ff <= remaining_in;
         hdr_count_ff <= hdr_count_in;
         key_ff       <= key_in;
         key_index_ff <= key_index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff       <= rsp_data_in;
         rsp_data_valid_ff <= rsp_data_valid_in;
         rsp_opcode_ff     <= rsp_opcode_in;
         rsp_fin_ff        <= rsp_fin_in;
         rsp_last_ff       <= rsp_last_in;
         rsp_error_ff      <= rsp_error_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_byte   = rsp_data_ff;
   assign rsp_payload_valid  = rsp_data_valid_ff;
   assign rsp_opcode         = rsp_opcode_ff;
   assign rsp_final_fragment = rsp_fin_ff;
   assign rsp_frame_last     = rsp_last_ff;
   assign rsp_protocol_error = rsp_error_ff;

endmodule

`default_nettype wire
